[sv/hsssc_pkg.sv]
`timescale 1ns / 1ps
// Package for the half-step stepper seek controller.
// Opcodes, run modes, reply kinds, result struct and the half-step table; no dependencies.
package hsssc_pkg;

    // Command opcodes
    localparam logic [2:0] OP_VERSION = 3'd0;
    localparam logic [2:0] OP_FORWARD = 3'd1;
    localparam logic [2:0] OP_REVERSE = 3'd2;
    localparam logic [2:0] OP_SET_POS = 3'd3;
    localparam logic [2:0] OP_GET_POS = 3'd4;
    localparam logic [2:0] OP_SEEK    = 3'd5;
    localparam logic [2:0] OP_RELEASE = 3'd6;
    localparam logic [2:0] OP_TICK    = 3'd7;

    // Run modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_REV  = 2'd2;
    localparam logic [1:0] MODE_SEEK = 2'd3;

    // Reply kinds
    localparam logic [1:0] REPLY_NONE     = 2'd0;
    localparam logic [1:0] REPLY_VERSION  = 2'd1;
    localparam logic [1:0] REPLY_POSITION = 2'd2;

    localparam int STEP_COUNT    = 8;
    localparam int IDX_W         = $clog2(STEP_COUNT);
    localparam int POSITION_BITS = 16;
    localparam int FIELD_POS_W   = 16;

    typedef struct packed {
        logic [3:0]             coil_drive;
        logic                   timer_on;
        logic [7:0]             timer_reload;
        logic [1:0]             reply_kind;
        logic [FIELD_POS_W-1:0] reply_position;
    } result_t;

    // Half-step coil pattern: 1,3,2,6,4,C,8,9
    function automatic logic [3:0] coil_pattern(input logic [IDX_W-1:0] idx);
        logic [3:0] pat;
        unique case (idx)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            3'd7: pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

[sv/hsssc_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one command or tick transaction.
// Depends on hsssc_pkg.
module hsssc_step #(
    parameter int POSITION_BITS = hsssc_pkg::POSITION_BITS
) (
    input  logic [2:0]                       opcode,
    input  logic [7:0]                       speed_value,
    input  logic signed [15:0]               position_value,
    input  logic [1:0]                       run_mode,
    input  logic [7:0]                       step_speed,
    input  logic [hsssc_pkg::IDX_W-1:0]      coil_index,
    input  logic signed [POSITION_BITS-1:0]  current_position,
    input  logic signed [POSITION_BITS-1:0]  target_position,
    input  logic [3:0]                       coil_latch,
    output logic [1:0]                       run_mode_next,
    output logic [7:0]                       step_speed_next,
    output logic [hsssc_pkg::IDX_W-1:0]      coil_index_next,
    output logic signed [POSITION_BITS-1:0]  current_position_next,
    output logic signed [POSITION_BITS-1:0]  target_position_next,
    output logic [3:0]                       coil_latch_next,
    output hsssc_pkg::result_t               result
);

    localparam int IW = hsssc_pkg::IDX_W;

    logic signed [POSITION_BITS-1:0] pos_in;
    logic [1:0]                      reply_kind;
    logic                            do_fwd;
    logic                            do_rev;

    // sign-extend or truncate the 16-bit field to the counter width
    assign pos_in = POSITION_BITS'(position_value);

    always_comb
    begin
        run_mode_next         = run_mode;
        step_speed_next       = step_speed;
        coil_index_next       = coil_index;
        current_position_next = current_position;
        target_position_next  = target_position;
        coil_latch_next       = coil_latch;
        reply_kind            = hsssc_pkg::REPLY_NONE;
        do_fwd                = 1'b0;
        do_rev                = 1'b0;

        unique case (opcode)
            hsssc_pkg::OP_VERSION: reply_kind = hsssc_pkg::REPLY_VERSION;
            hsssc_pkg::OP_FORWARD:
            begin
                run_mode_next   = hsssc_pkg::MODE_FWD;
                step_speed_next = speed_value;
            end
            hsssc_pkg::OP_REVERSE:
            begin
                run_mode_next   = hsssc_pkg::MODE_REV;
                step_speed_next = speed_value;
            end
            hsssc_pkg::OP_SET_POS: current_position_next = pos_in;
            hsssc_pkg::OP_GET_POS: reply_kind = hsssc_pkg::REPLY_POSITION;
            hsssc_pkg::OP_SEEK:
            begin
                target_position_next = pos_in;
                run_mode_next        = hsssc_pkg::MODE_SEEK;
                step_speed_next      = speed_value;
            end
            hsssc_pkg::OP_RELEASE:
            begin
                coil_latch_next = 4'h0;
                run_mode_next   = hsssc_pkg::MODE_IDLE;
            end
            hsssc_pkg::OP_TICK:
            begin
                unique case (run_mode)
                    hsssc_pkg::MODE_FWD:  do_fwd = 1'b1;
                    hsssc_pkg::MODE_REV:  do_rev = 1'b1;
                    hsssc_pkg::MODE_SEEK:
                    begin
                        if (current_position < target_position)
                            do_fwd = 1'b1;
                        else if (current_position > target_position)
                            do_rev = 1'b1;
                        else
                            step_speed_next = 8'd0;  // arrived: stop timer
                    end
                    hsssc_pkg::MODE_IDLE: ;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (do_fwd)
        begin
            current_position_next = current_position + POSITION_BITS'(1);
            coil_index_next       = coil_index + IW'(1);
            coil_latch_next       = hsssc_pkg::coil_pattern(coil_index + IW'(1));
        end
        else if (do_rev)
        begin
            current_position_next = current_position - POSITION_BITS'(1);
            coil_index_next       = coil_index - IW'(1);
            coil_latch_next       = hsssc_pkg::coil_pattern(coil_index - IW'(1));
        end
    end

    always_comb
    begin
        result.coil_drive     = coil_latch_next;
        result.timer_on       = (step_speed_next != 8'd0);
        result.timer_reload   = step_speed_next;
        result.reply_kind     = reply_kind;
        result.reply_position = (reply_kind == hsssc_pkg::REPLY_POSITION) ?
            hsssc_pkg::FIELD_POS_W'($unsigned(current_position)) : '0;
    end

endmodule

[sv/half_step_stepper_seek_controller.sv]
`timescale 1ns / 1ps
// Half-step stepper seek controller, top level: state registers and result skid buffer.
// Depends on hsssc_pkg and hsssc_step.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall): opcode, speed_value, position_value.
//   A transaction is a command (version, forward, reverse, set/get position,
//   seek, release) or a timer tick (opcode 7) from the external step timer.
//   Response channel (rsp_valid / rsp_stall): exactly one result per command
//   transaction: coil_drive, timer_on, timer_reload, reply_kind, reply_position.
//   The timer_reload / timer_on outputs load the external tick timer.
// A result goes to the output register, or to the skid entry if the output is busy.
// Throughput: one transaction per cycle when not stalled; the whole update is a
//   single pass of compare, increment and table lookup between the state registers.
// Stall: results go to an output register backed by one skid entry, so the
//   block keeps taking commands while one result waits. cmd_stall rises only
//   once both entries hold results; it is driven straight from a flop.
// Reset: run mode idle, speed 0, coil index 0, position and target 0, coils
//   off, no result pending.
module half_step_stepper_seek_controller #(
    parameter int POSITION_BITS = hsssc_pkg::POSITION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         opcode,
    input  logic [7:0]         speed_value,
    input  logic signed [15:0] position_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [3:0]         coil_drive,
    output logic               timer_on,
    output logic [7:0]         timer_reload,
    output logic [1:0]         reply_kind,
    output logic signed [15:0] reply_position
);

    localparam int IW = hsssc_pkg::IDX_W;

    // controller state
    logic [1:0]                      run_mode_reg,         run_mode_next;
    logic [7:0]                      step_speed_reg,       step_speed_next;
    logic [IW-1:0]                   coil_index_reg,       coil_index_next;
    logic signed [POSITION_BITS-1:0] current_position_reg, current_position_next;
    logic signed [POSITION_BITS-1:0] target_position_reg,  target_position_next;
    logic [3:0]                      coil_latch_reg,       coil_latch_next;

    // result register plus skid entry
    hsssc_pkg::result_t result;
    hsssc_pkg::result_t rsp_data_reg;
    hsssc_pkg::result_t skid_data_reg;
    logic               rsp_valid_reg;
    logic               skid_valid_reg;

    logic cmd_accept;
    logic rsp_drain;

    assign cmd_stall  = skid_valid_reg;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_drain  = rsp_valid_reg && !rsp_stall;

    hsssc_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .opcode                (opcode),
        .speed_value           (speed_value),
        .position_value        (position_value),
        .run_mode              (run_mode_reg),
        .step_speed            (step_speed_reg),
        .coil_index            (coil_index_reg),
        .current_position      (current_position_reg),
        .target_position       (target_position_reg),
        .coil_latch            (coil_latch_reg),
        .run_mode_next         (run_mode_next),
        .step_speed_next       (step_speed_next),
        .coil_index_next       (coil_index_next),
        .current_position_next (current_position_next),
        .target_position_next  (target_position_next),
        .coil_latch_next       (coil_latch_next),
        .result                (result)
    );

    // State commits on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg         <= hsssc_pkg::MODE_IDLE;
            step_speed_reg       <= 8'd0;
            coil_index_reg       <= '0;
            current_position_reg <= '0;
            target_position_reg  <= '0;
            coil_latch_reg       <= 4'h0;
        end
        else if (cmd_accept)
        begin
            run_mode_reg         <= run_mode_next;
            step_speed_reg       <= step_speed_next;
            coil_index_reg       <= coil_index_next;
            current_position_reg <= current_position_next;
            target_position_reg  <= target_position_next;
            coil_latch_reg       <= coil_latch_next;
        end
    end

    // Output valid flags. Accept only happens with the skid entry empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd_accept)
            begin
                rsp_valid_reg <= 1'b1;
                if (rsp_valid_reg && !rsp_drain)
                    skid_valid_reg <= 1'b1;    // output busy: park in skid
            end
            else if (rsp_drain)
            begin
                rsp_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                // nothing moves: hold
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        priority if (cmd_accept)
        begin
            if (rsp_valid_reg && !rsp_drain)
                skid_data_reg <= result;
            else
                rsp_data_reg  <= result;
        end
        else if (rsp_drain && skid_valid_reg)
            rsp_data_reg <= skid_data_reg;
        else
        begin
            // nothing moves: hold
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign coil_drive     = rsp_data_reg.coil_drive;
    assign timer_on       = rsp_data_reg.timer_on;
    assign timer_reload   = rsp_data_reg.timer_reload;
    assign reply_kind     = rsp_data_reg.reply_kind;
    assign reply_position = rsp_data_reg.reply_position;

    // Skid entry is only ever filled behind a held result
    a_skid_behind_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid entry valid without pending result");

    // Coils are either released or show the pattern of the current index
    a_latch_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        (coil_latch_reg == 4'h0) ||
        (coil_latch_reg == hsssc_pkg::coil_pattern(coil_index_reg)))
        else $error("coil latch out of step with coil index");

    // Release leaves the coils off and the mode idle
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && opcode == hsssc_pkg::OP_RELEASE) |=>
        (coil_latch_reg == 4'h0 && run_mode_reg == hsssc_pkg::MODE_IDLE))
        else $error("release did not clear coils and mode");

    // Timer enable follows the reload value
    a_timer_on: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (timer_on == (timer_reload != 8'd0)))
        else $error("timer_on disagrees with timer_reload");

    // Position field is zero unless it carries a position reply
    a_reply_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && reply_kind != hsssc_pkg::REPLY_POSITION) |->
        (reply_position == 16'sd0))
        else $error("reply_position nonzero without position reply");

endmodule
